### src/met_pkg.sv
//----------------------------------------------------------------------------
// met_pkg
// Shared types and constants for the escape-time pixel block.
//----------------------------------------------------------------------------
`default_nettype none

package met_pkg;

   // Field widths
   localparam int COORD_W = 10;
   localparam int COLOR_W = 32;
   localparam int COUNT_W = 8;
   localparam int STEP_W  = 24;

   // Q4.28 fixed point, Q8.56 products
   localparam int Q_W    = 32;
   localparam int FRAC_W = 28;
   localparam int PROD_W = 2 * Q_W;

   localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

   // |z|^2 = 4.0 at Q8.56
   localparam logic [PROD_W-1:0] ESC_LIMIT = 64'h0400_0000_0000_0000;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_STEP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITER   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DARK       = 2'd2;

   localparam logic [STEP_W-1:0]  COLOR_STEP_RST = 24'd272;
   localparam logic [COUNT_W-1:0] MAX_ITER_RST   = 8'd50;
   localparam logic [COUNT_W-1:0] DARK_RST       = 8'd25;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_col;
      logic [COORD_W-1:0] pixel_row;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] out_col;
      logic [COORD_W-1:0] out_row;
      logic [COLOR_W-1:0] pixel_color;
      logic [COUNT_W-1:0] iter_count;
   } rsp_type;

   // Operand selection of the shared multiplier
   typedef enum logic [1:0] {
      MUL_RR,
      MUL_II,
      MUL_RI,
      MUL_COLOR
   } mul_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP,
      ST_SQ_R,
      ST_SQ_I,
      ST_CROSS,
      ST_UPDATE,
      ST_COLOR,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

### src/mandelbrot_escape_time_pixel.sv
//----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time count and color for one pixel, iterated on one shared
// multiplier under a small sequencer.
//----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Payload
// req_      in         start & !busy             req_data  (req_type)
// rsp_      out        rsp_valid, 1-cycle strobe rsp_data  (rsp_type)
// csr_      in         csr_valid & csr_ready     csr_index, csr_data
//
// Sequence: an item first maps the position (offset, then a constant
//   reciprocal multiply), then runs passes on the single multiplier (zr*zr,
//   zi*zi, zr*zi, update), n + 1 in all with the pass that finds the stop,
//   n = iterations done (0..max_iterations); the color product reuses the
//   multiplier.
// busy is high from accept until the result is registered; the strobe
//   appears as busy drops, so the next item can be taken in that cycle.
// Reset (synchronous) returns the sequencer to idle, drops the strobe and
//   loads the register reset values. Results cannot be stalled.
// csr_ready is always high; writes to unknown indexes are dropped.
//----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time_pixel
   import met_pkg::*;
#(
   parameter int COLS = 1024,
   parameter int ROWS = 1024
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // item in
   input  wire logic                  start,
   output      logic                  busy,
   input  wire req_type               req_data,
   // result out
   output      logic                  rsp_valid,
   output      rsp_type               rsp_data,
   // configuration
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int SUM_W = 40;
   localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(Q_MAX);
   localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(Q_MIN);

   function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
      logic signed [Q_W-1:0] r;
      if (v > SUM_MAX) begin
         r = Q_MAX;
      end else if (v < SUM_MIN) begin
         r = Q_MIN;
      end else begin
         r = v[Q_W-1:0];
      end
      return r;
   endfunction

   // Sequencer
   state_type              state_ff;
   state_type              state_in;
   logic                   accept;
   logic                   map_load;
   mul_sel_type            mul_sel;

   // Configuration registers
   logic [STEP_W-1:0]      color_step_ff;
   logic [COUNT_W-1:0]     max_iter_ff;
   logic [COUNT_W-1:0]     dark_ff;

   // Datapath
   req_type                req_ff;
   logic signed [Q_W-1:0]  cr_ff;
   logic signed [Q_W-1:0]  ci_ff;
   logic signed [Q_W-1:0]  zr_ff;
   logic signed [Q_W-1:0]  zi_ff;
   logic [PROD_W-1:0]      rr_ff;
   logic signed [PROD_W-1:0] diff_ff;
   logic                   esc_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic                   stop;

   logic                   col_done;
   logic                   row_done;
   logic signed [Q_W-1:0]  col_coord;
   logic signed [Q_W-1:0]  row_coord;
   logic signed [PROD_W-1:0] prod;
   logic signed [SUM_W-1:0] zr_sum;
   logic signed [SUM_W-1:0] zi_sum;
   logic [PROD_W-1:0]      mag_sum;

   rsp_type                rsp_data_ff;
   logic                   rsp_valid_ff;

   assign accept    = start && (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   // Coordinate mapping, both axes in parallel
   met_coord_div #(.SIZE(COLS)) u_col_div (
      .clock (clock),
      .reset (reset),
      .load  (map_load),
      .pos   (req_data.pixel_col),
      .done  (col_done),
      .coord (col_coord)
   );

   met_coord_div #(.SIZE(ROWS)) u_row_div (
      .clock (clock),
      .reset (reset),
      .load  (map_load),
      .pos   (req_data.pixel_row),
      .done  (row_done),
      .coord (row_coord)
   );

   met_mul u_mul (
      .clock      (clock),
      .sel        (mul_sel),
      .zr         (zr_ff),
      .zi         (zi_ff),
      .color_step (color_step_ff),
      .count      (count_ff),
      .prod       (prod)
   );

   // Escape when |z|^2 >= 4, otherwise stop at the iteration limit
   assign stop = esc_ff || (count_ff >= max_iter_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (start) state_in = ST_MAP;
         ST_MAP:    if (col_done && row_done) state_in = ST_SQ_R;
         ST_SQ_R:   state_in = ST_SQ_I;
         ST_SQ_I:   state_in = ST_CROSS;
         ST_CROSS:  state_in = ST_UPDATE;
         ST_UPDATE: state_in = stop ? ST_COLOR : ST_SQ_R;
         ST_COLOR:  state_in = ST_DONE;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs; other states keep the color operands selected
   always_comb begin
      busy     = 1'b1;
      map_load = 1'b0;
      mul_sel  = MUL_COLOR;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            map_load = start;
         end
         ST_SQ_R:  mul_sel = MUL_RR;
         ST_SQ_I:  mul_sel = MUL_II;
         ST_CROSS: mul_sel = MUL_RI;
         default:  busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         color_step_ff <= COLOR_STEP_RST;
         max_iter_ff   <= MAX_ITER_RST;
         dark_ff       <= DARK_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COLOR_STEP: color_step_ff <= csr_data;
            CSR_MAX_ITER:   max_iter_ff   <= csr_data[COUNT_W-1:0];
            CSR_DARK:       dark_ff       <= csr_data[COUNT_W-1:0];
            default:        ;
         endcase
      end
   end

   // new zr = floor((rr - ii) / 2^28) + cr, new zi = floor(ri / 2^27) + ci
   assign zr_sum  = SUM_W'($signed(diff_ff[PROD_W-1:FRAC_W])) + SUM_W'(cr_ff);
   assign zi_sum  = SUM_W'($signed(prod[PROD_W-1:FRAC_W-1])) + SUM_W'(ci_ff);
   // squares are non-negative and at most 2^62, so the sum cannot wrap
   assign mag_sum = rr_ff + $unsigned(prod);

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (state_ff == ST_MAP) begin
         cr_ff    <= col_coord;
         ci_ff    <= row_coord;
         zr_ff    <= '0;
         zi_ff    <= '0;
         count_ff <= '0;
      end
      // prod holds zr*zr here
      if (state_ff == ST_SQ_I) begin
         rr_ff <= $unsigned(prod);
      end
      // prod holds zi*zi here
      if (state_ff == ST_CROSS) begin
         diff_ff <= $signed(rr_ff) - prod;
         esc_ff  <= mag_sum >= ESC_LIMIT;
      end
      // prod holds zr*zi here
      if ((state_ff == ST_UPDATE) && !stop) begin
         zr_ff    <= sat_q(zr_sum);
         zi_ff    <= sat_q(zi_sum);
         count_ff <= count_ff + 1'b1;
      end
      // prod holds color_step*count here
      if (state_ff == ST_DONE) begin
         rsp_data_ff.out_col     <= req_ff.pixel_col;
         rsp_data_ff.out_row     <= req_ff.pixel_row;
         rsp_data_ff.pixel_color <= (count_ff < dark_ff) ? prod[COLOR_W-1:0] : '0;
         rsp_data_ff.iter_count  <= count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_DONE);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### src/met_coord_div.sv
//----------------------------------------------------------------------------
// met_coord_div
// Maps a pixel position to a Q4.28 coordinate in -2..+2, dividing by the
// grid size with a constant reciprocal multiply on the registered offset.
//----------------------------------------------------------------------------
`default_nettype none

module met_coord_div
   import met_pkg::*;
#(
   parameter int SIZE = 1024
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire logic [COORD_W-1:0]    pos,
   output      logic                  done,
   output      logic signed [Q_W-1:0] coord
);

   localparam int SW = $clog2(SIZE + 1);
   localparam int DW = ((SW > COORD_W + 1) ? SW : COORD_W + 1) + 2;
   // 2^KS >= 4*SIZE^2 keeps the reciprocal error below one quotient step
   localparam int KS = 2 * $clog2(SIZE) + 2;
   localparam int MW = $clog2(SIZE) + 32;
   localparam int PW = DW + MW;
   localparam logic [DW:0]   SAT_LIM = (DW + 1)'(4 * SIZE);
   // ceil(2^(29+KS) / SIZE)
   localparam logic [MW-1:0] RECIP   =
      MW'(((64'd1 << (29 + KS)) + 64'(SIZE - 1)) / 64'(SIZE));

   logic signed [DW-1:0]  diff;
   logic [DW-1:0]         mag;
   logic                  sat;
   logic [PW-1:0]         scaled;

   logic [DW-1:0]         mag_ff;
   logic [Q_W-2:0]        quot_ff;
   logic                  neg_ff;
   logic                  sat_ff;
   logic                  run_ff;

   // 2*pos - SIZE, its magnitude; positive side saturates at 4*SIZE
   assign diff = $signed({{(DW - COORD_W - 1){1'b0}}, pos, 1'b0}) - $signed(DW'(SIZE));
   assign mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);
   assign sat  = !diff[DW-1] && ({1'b0, mag} >= SAT_LIM);

   // mag * 2^29 / SIZE, truncated
   assign scaled = PW'(mag_ff) * PW'(RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mag_ff <= mag;
         neg_ff <= diff[DW-1];
         sat_ff <= sat;
      end
      if (run_ff) begin
         quot_ff <= scaled[KS +: Q_W - 1];
      end
   end

   assign done = !run_ff;

   always_comb begin
      if (sat_ff) begin
         coord = Q_MAX;
      end else if (neg_ff) begin
         coord = -$signed({1'b0, quot_ff});
      end else begin
         coord = $signed({1'b0, quot_ff});
      end
   end

endmodule

`default_nettype wire

### src/met_mul.sv
//----------------------------------------------------------------------------
// met_mul
// Shared 32x32 signed multiplier with operand select and registered product.
//----------------------------------------------------------------------------
`default_nettype none

module met_mul
   import met_pkg::*;
(
   input  wire logic                     clock,
   input  wire mul_sel_type              sel,
   input  wire logic signed [Q_W-1:0]    zr,
   input  wire logic signed [Q_W-1:0]    zi,
   input  wire logic [STEP_W-1:0]        color_step,
   input  wire logic [COUNT_W-1:0]       count,
   output      logic signed [PROD_W-1:0] prod
);

   logic signed [Q_W-1:0]    op_a;
   logic signed [Q_W-1:0]    op_b;
   logic signed [PROD_W-1:0] prod_ff;

   always_comb begin
      unique case (sel)
         MUL_RR: begin
            op_a = zr;
            op_b = zr;
         end
         MUL_II: begin
            op_a = zi;
            op_b = zi;
         end
         MUL_RI: begin
            op_a = zr;
            op_b = zi;
         end
         MUL_COLOR: begin
            op_a = $signed({{(Q_W - STEP_W){1'b0}}, color_step});
            op_b = $signed({{(Q_W - COUNT_W){1'b0}}, count});
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire
